// ----- rtl/lbs_pkg.sv -----
package lbs_pkg;

    localparam int WORDS_PER_JOINT = 12;
    localparam int WEIGHT_FRAC     = 15;
    localparam int S_TDATA_W       = 176;
    localparam int M_TDATA_W       = 112;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_BLEND = 1'b1;

    // what the back end does with a queued item
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_BLEND,
        KIND_EMIT
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [5:0]         joint;
        logic [3:0]         word;
        logic signed [31:0] word_value;
        logic [15:0]        weight;
        logic signed [31:0] bind_x;
        logic signed [31:0] bind_y;
        logic signed [31:0] bind_z;
        logic               last;
        logic [15:0]        vertex;
    } item_t;

endpackage

// ----- rtl/lbs_front.sv -----
module lbs_front
    import lbs_pkg::*;
#(
    parameter int JOINT_COUNT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    item_t         fifo_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    item_t in_item;
    logic  joint_ok;
    logic  word_ok;
    logic  keep;
    logic  push;

    always_comb begin
        in_item.joint      = s_tdata[5:0];
        in_item.word       = s_tdata[9:6];
        in_item.word_value = s_tdata[41:10];
        in_item.weight     = s_tdata[57:42];
        in_item.bind_x     = s_tdata[89:58];
        in_item.bind_y     = s_tdata[121:90];
        in_item.bind_z     = s_tdata[153:122];
        in_item.vertex     = s_tdata[169:154];
        in_item.last       = s_tlast;
        joint_ok = int'(in_item.joint) < JOINT_COUNT;
        word_ok  = int'(in_item.word) < WORDS_PER_JOINT;
        // out-of-range loads and non-final out-of-range influences are dropped
        if (s_tuser == ACTION_LOAD) begin
            in_item.kind = KIND_LOAD;
            keep         = joint_ok && word_ok;
        end else if (joint_ok) begin
            in_item.kind = KIND_BLEND;
            keep         = 1'b1;
        end else begin
            in_item.kind = KIND_EMIT;
            keep         = s_tlast;
        end
    end

    assign s_tready   = count_reg != (PW+1)'(DEPTH);
    assign push       = s_tvalid && s_tready && keep;
    assign q_valid    = count_reg != '0;
    assign q_item     = fifo_reg[rd_ptr_reg];
    assign count_next = count_reg + (PW+1)'(push) - (PW+1)'(q_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/lbs_back.sv -----
module lbs_back
    import lbs_pkg::*;
#(
    parameter int JOINT_COUNT = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PAL_DEPTH = JOINT_COUNT * WORDS_PER_JOINT;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int PROD_W    = 64;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 2;
    localparam int WPROD_W   = 49;
    localparam int WTERM_W   = WPROD_W - WEIGHT_FRAC;
    localparam int ACC_W     = 64;

    localparam logic signed [31:0] ONE_Q     = 32'(1 << FRAC_BITS);
    localparam logic [3:0]         LAST_WORD = 4'(WORDS_PER_JOINT - 1);

    localparam logic [1:0] COL_X     = 2'd0;
    localparam logic [1:0] COL_Y     = 2'd1;
    localparam logic [1:0] COL_Z     = 2'd2;
    localparam logic [1:0] COL_TRANS = 2'd3;
    localparam logic [1:0] ROW_X     = 2'd0;
    localparam logic [1:0] ROW_Y     = 2'd1;
    localparam logic [1:0] ROW_Z     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    function automatic logic [PAL_AW-1:0] pal_addr(input logic [5:0] j, input logic [3:0] w);
        pal_addr = PAL_AW'(int'(j) * WORDS_PER_JOINT + int'(w));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (&v[63:31] || ~|v[63:31]) begin
            sat32 = v[31:0];
        end else begin
            sat32 = v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    endfunction

    state_t                 state_reg;
    logic [3:0]             word_cnt_reg;
    item_t                  cur_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic signed [31:0]     pal_mem [PAL_DEPTH];
    logic signed [31:0]     mem_q_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [PAL_AW-1:0]      mem_addr;

    logic                   rd_v_reg;
    logic [1:0]             rd_col_reg;
    logic [1:0]             rd_row_reg;
    logic                   pr_v_reg;
    logic [1:0]             pr_col_reg;
    logic [1:0]             pr_row_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                   rs_v_reg;
    logic [1:0]             rs_row_reg;
    logic signed [SUM_W-1:0] row_sum_reg;
    logic                   wp_v_reg;
    logic [1:0]             wp_row_reg;
    logic signed [WPROD_W-1:0] wprod_reg;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic signed [ACC_W-1:0] acc_z_reg;

    logic                   pipe_busy;
    logic                   out_free;
    logic                   emit;
    logic signed [31:0]     mul_b;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0] row_base;
    logic signed [31:0]     row_sat;
    logic signed [16:0]     weight_s;
    logic signed [WTERM_W-1:0] wterm;
    logic signed [ACC_W-1:0] acc_cur;
    logic signed [ACC_W:0]  acc_wide;
    logic signed [ACC_W-1:0] acc_sum;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign mem_we    = q_pop && (q_item.kind == KIND_LOAD);
    assign mem_re    = state_reg == ST_RUN;
    assign mem_addr  = mem_we ? pal_addr(q_item.joint, q_item.word)
                              : pal_addr(cur_reg.joint, word_cnt_reg);
    assign pipe_busy = rd_v_reg || pr_v_reg || rs_v_reg || wp_v_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == ST_EMIT) && out_free;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // palette: one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pal_mem[mem_addr] <= q_item.word_value;
        end
        if (mem_re) begin
            mem_q_reg <= pal_mem[mem_addr];
        end
    end

    always_comb begin
        case (rd_col_reg)
            COL_X:   mul_b = cur_reg.bind_x;
            COL_Y:   mul_b = cur_reg.bind_y;
            COL_Z:   mul_b = cur_reg.bind_z;
            default: mul_b = ONE_Q;
        endcase
        case (wp_row_reg)
            ROW_Y:   acc_cur = acc_y_reg;
            ROW_Z:   acc_cur = acc_z_reg;
            default: acc_cur = acc_x_reg;
        endcase
        term     = TERM_W'(prod_reg >>> FRAC_BITS);
        row_base = (pr_col_reg == COL_X) ? '0 : row_sum_reg;
        row_sat  = sat32(64'(row_sum_reg));
        weight_s = $signed({1'b0, cur_reg.weight});
        wterm    = WTERM_W'(wprod_reg >>> WEIGHT_FRAC);
        acc_wide = (ACC_W+1)'(acc_cur) + (ACC_W+1)'(wterm);
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
            acc_sum = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sum = acc_wide[ACC_W-1:0];
        end
    end

    // read -> multiply -> row sum -> weight multiply -> accumulate
    always_ff @(posedge aclk) begin
        rd_col_reg <= word_cnt_reg[1:0];
        rd_row_reg <= word_cnt_reg[3:2];
        prod_reg   <= mem_q_reg * mul_b;
        pr_col_reg <= rd_col_reg;
        pr_row_reg <= rd_row_reg;
        if (pr_v_reg) begin
            row_sum_reg <= row_base + SUM_W'(term);
        end
        rs_row_reg <= pr_row_reg;
        wprod_reg  <= row_sat * weight_s;
        wp_row_reg <= rs_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            pr_v_reg  <= 1'b0;
            rs_v_reg  <= 1'b0;
            wp_v_reg  <= 1'b0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end else begin
            rd_v_reg <= mem_re;
            pr_v_reg <= rd_v_reg;
            rs_v_reg <= pr_v_reg && (pr_col_reg == COL_TRANS);
            wp_v_reg <= rs_v_reg;
            if (emit) begin
                acc_x_reg <= '0;
                acc_y_reg <= '0;
                acc_z_reg <= '0;
            end else if (wp_v_reg) begin
                case (wp_row_reg)
                    ROW_X:   acc_x_reg <= acc_sum;
                    ROW_Y:   acc_y_reg <= acc_sum;
                    ROW_Z:   acc_z_reg <= acc_sum;
                    default: acc_x_reg <= acc_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            word_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !emit) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cur_reg      <= q_item;
                        word_cnt_reg <= '0;
                        case (q_item.kind)
                            KIND_BLEND: state_reg <= ST_RUN;
                            KIND_EMIT:  state_reg <= ST_EMIT;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RUN: begin
                    word_cnt_reg <= word_cnt_reg + 4'd1;
                    if (word_cnt_reg == LAST_WORD) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= cur_reg.last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {sat32(acc_z_reg), sat32(acc_y_reg),
                                         sat32(acc_x_reg), cur_reg.vertex};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_emit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !pipe_busy)
        else $error("result taken while influence still in flight");

    a_row_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        rs_v_reg |-> $past(pr_v_reg && (pr_col_reg == COL_TRANS)))
        else $error("row sum marked done before translation word");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (acc_x_reg == '0 && acc_y_reg == '0 && acc_z_reg == '0))
        else $error("accumulators not cleared on result");

    a_acc_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_v_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("accumulate outside influence work");

endmodule

// ----- rtl/linear_blend_skinning.sv -----
// Linear blend skinning engine.
// s_ channel: palette loads (s_tuser = 0) and vertex influences (s_tuser = 1);
//   s_tlast marks the final influence of a vertex.
// m_ channel: one skinned position per vertex, sent after its final influence.
// A palette load is written to the palette as the back end pops it. An
// influence makes 12 single-port palette reads, one per cycle, then the 5-stage
// multiply / row-sum / weight / accumulate pipeline drains. Once the last
// influence of a vertex has drained, the result is registered when the output is free.
// A 2-entry item queue sits between the front and back ends; s_tready drops
// only when it is full. A stalled m_ channel holds the result register; the
// back end then waits before emitting the next result but keeps taking
// influences that do not end a vertex.
// Reset clears the accumulators, the queue and the output valid. The palette
// is not cleared: every matrix must be loaded before it is used.
module linear_blend_skinning
    import lbs_pkg::*;
#(
    parameter int JOINT_COUNT = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // joint_index, word_index, word_value, weight, bind_x, bind_y, bind_z,
    // vertex_id, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_vertex, out_x, out_y, out_z
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    lbs_front #(
        .JOINT_COUNT(JOINT_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    lbs_back #(
        .JOINT_COUNT(JOINT_COUNT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// ----- test/skin_checker.sv -----
module skin_checker
    import lbs_pkg::*;
#(
    parameter int JOINT_COUNT = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   errors,
    output int                   pending
);

    localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
    localparam longint MIN32 = -MAX32 - 1;
    localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint MIN64 = -MAX64 - 1;

    typedef struct packed {
        logic [15:0] vertex;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } position_t;

    position_t          skinned_positions[$];
    logic signed [31:0] palette [JOINT_COUNT][WORDS_PER_JOINT];
    longint             acc_x;
    longint             acc_y;
    longint             acc_z;

    initial begin
        errors  = 0;
        pending = 0;
        acc_x   = 0;
        acc_y   = 0;
        acc_z   = 0;
    end

    function automatic longint clamp32(longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    function automatic longint acc_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0) return MAX64;
        if (a < 0 && b < 0 && s >= 0) return MIN64;
        return s;
    endfunction

    // weight * (row . [x y z 1]), products floored to Q16.16, row sum saturated
    function automatic longint blend_row(int joint, int row, logic signed [31:0] bx,
                                         logic signed [31:0] by, logic signed [31:0] bz,
                                         logic [15:0] weight);
        longint s;
        s = ((longint'(palette[joint][4*row])   * longint'(bx)) >>> FRAC_BITS)
          + ((longint'(palette[joint][4*row+1]) * longint'(by)) >>> FRAC_BITS)
          + ((longint'(palette[joint][4*row+2]) * longint'(bz)) >>> FRAC_BITS)
          + longint'(palette[joint][4*row+3]);
        s = clamp32(s);
        return (s * longint'(weight)) >>> WEIGHT_FRAC;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        logic [5:0]         joint;
        logic [3:0]         word;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic [15:0]        weight;
        position_t          want;
        position_t          pos;

        if (!aresetn) begin
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            skinned_positions.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (skinned_positions.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = skinned_positions.pop_front();
                    check_field("out_vertex", 32'(want.vertex), 32'(m_tdata[15:0]));
                    check_field("out_x", want.x, m_tdata[47:16]);
                    check_field("out_y", want.y, m_tdata[79:48]);
                    check_field("out_z", want.z, m_tdata[111:80]);
                end
            end
            if (s_tvalid && s_tready) begin
                joint  = s_tdata[5:0];
                word   = s_tdata[9:6];
                weight = s_tdata[57:42];
                bx     = s_tdata[89:58];
                by     = s_tdata[121:90];
                bz     = s_tdata[153:122];
                if (s_tuser == ACTION_LOAD) begin
                    if (joint < JOINT_COUNT && word < WORDS_PER_JOINT)
                        palette[joint][word] = s_tdata[41:10];
                end else begin
                    if (joint < JOINT_COUNT) begin
                        acc_x = acc_add(acc_x, blend_row(joint, 0, bx, by, bz, weight));
                        acc_y = acc_add(acc_y, blend_row(joint, 1, bx, by, bz, weight));
                        acc_z = acc_add(acc_z, blend_row(joint, 2, bx, by, bz, weight));
                    end
                    if (s_tlast) begin
                        pos.vertex = s_tdata[169:154];
                        pos.x      = 32'(clamp32(acc_x));
                        pos.y      = 32'(clamp32(acc_y));
                        pos.z      = 32'(clamp32(acc_z));
                        skinned_positions.push_back(pos);
                        acc_x = 0;
                        acc_y = 0;
                        acc_z = 0;
                    end
                end
            end
        end
        pending = skinned_positions.size();
    end

endmodule

// ----- test/tb_linear_blend_skinning.sv -----
module tb_linear_blend_skinning;
    import lbs_pkg::*;

    localparam int JOINT_COUNT  = 64;
    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int WATCHDOG     = 3000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int          fails;
    int          pending;
    int          idle_cycles = 0;
    int          src_idle_pct = 16;
    int          m_stall_pct = 72;
    int          item_count = 0;
    logic [11:0] words_loaded [JOINT_COUNT];
    int          usable_joints[$];

    linear_blend_skinning #(
        .JOINT_COUNT(JOINT_COUNT),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    skin_checker #(
        .JOINT_COUNT(JOINT_COUNT),
        .FRAC_BITS  (FRAC_BITS)
    ) i_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .errors  (fails),
        .pending (pending)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= m_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_q16(int unsigned span);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4) return Q_MAX;
        if (roll < 8) return Q_MIN;
        if (roll < 20) return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic logic [15:0] pick_weight();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return 16'h0000;
        if (roll < 15) return 16'h8000;
        if (roll < 30) return 16'($urandom_range(65535));
        return 16'($urandom_range(32768));
    endfunction

    function automatic logic [31:0] matrix_word(int word);
        return (word % 4 == 3) ? pick_q16(64 << 16) : pick_q16(2 << 16);
    endfunction

    // joint 63 test matrix: extremes in row 0, unit, zero and extreme words in the rows below
    function automatic logic [31:0] probe_word(int word);
        case (word)
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return Q_ONE;
            3:       return Q_MAX;
            4:       return Q_ONE;
            7:       return Q_MIN;
            8:       return -Q_ONE;
            9:       return Q_ONE;
            10:      return Q_MIN;
            11:      return 32'h0001_8000;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic push_item(input logic act, input logic [5:0] joint, input logic [3:0] word,
                             input logic [31:0] wval, input logic [15:0] weight,
                             input logic [31:0] bx, input logic [31:0] by,
                             input logic [31:0] bz, input logic last,
                             input logic [15:0] vid);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tlast  <= last;
        s_tdata  <= {6'd0, vid, bz, by, bx, weight, wval, word, joint};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (act == ACTION_LOAD && word >= WORDS_PER_JOINT)
            return;
        item_count++;
        if (act == ACTION_LOAD) begin
            if (words_loaded[joint] != 12'hFFF) begin
                words_loaded[joint][word] = 1'b1;
                if (words_loaded[joint] == 12'hFFF)
                    usable_joints.push_back(joint);
            end
        end
    endtask

    task automatic load_matrix(input logic [5:0] joint);
        for (int w = 0; w < WORDS_PER_JOINT; w++)
            push_item(ACTION_LOAD, joint, 4'(w), matrix_word(w), 16'($urandom), $urandom,
                      $urandom, $urandom, 1'($urandom_range(1)), 16'($urandom));
    endtask

    task automatic skin_vertex();
        int          n;
        logic [15:0] vid;
        n   = $urandom_range(1, 5);
        vid = 16'($urandom);
        for (int i = 0; i < n; i++)
            push_item(ACTION_BLEND,
                      6'(usable_joints[$urandom_range(usable_joints.size() - 1)]),
                      4'($urandom), $urandom, pick_weight(), pick_q16(8 << 16),
                      pick_q16(8 << 16), pick_q16(8 << 16), i == n - 1,
                      (i == n - 1) ? vid : 16'($urandom));
    endtask

    initial begin
        int unsigned roll;
        int          joint;
        int          word;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = ACTION_LOAD;
        s_tlast  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        for (int j = 0; j < JOINT_COUNT; j++)
            words_loaded[j] = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int w = 0; w < WORDS_PER_JOINT; w++)
            push_item(ACTION_LOAD, 6'd63, 4'(w), probe_word(w), 16'hFFFF, Q_MAX, Q_MIN, Q_MAX,
                      w == WORDS_PER_JOINT - 1, 16'hFFFF);
        // out-of-range words must not disturb the palette
        push_item(ACTION_LOAD, 6'd63, 4'd12, Q_MAX, 16'h0, 32'h0, 32'h0, 32'h0, 1'b0, 16'h0);
        push_item(ACTION_LOAD, 6'd63, 4'd15, Q_MIN, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1, 16'h0);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'hFFFF, Q_MAX, Q_MAX, Q_MAX, 1'b0, 16'h0);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'hFFFF, Q_MIN, Q_MIN, Q_MIN, 1'b0, 16'h0);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'h8000, Q_MAX, Q_MIN, 32'h0, 1'b1,
                  16'hFFFF);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'h0000, $urandom, $urandom, $urandom,
                  1'b1, 16'h0000);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'h8000, 32'h0, 32'h0, 32'h0, 1'b1,
                  16'h1234);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'hFFFF, Q_ONE, -Q_ONE, 32'h0002_0000,
                  1'b0, 16'h0);
        push_item(ACTION_BLEND, 6'd63, 4'd0, 32'h0, 16'hFFFF, Q_ONE, -Q_ONE, 32'h0002_0000,
                  1'b1, 16'hA5A5);

        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            if (item_count >= 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                m_stall_pct  = 0;
            end else if (item_count >= RANDOM_ITEMS / 3) begin
                src_idle_pct = 72;
                m_stall_pct  = 16;
            end
            roll = $urandom_range(99);
            if (usable_joints.size() < 4 || roll < 6) begin
                load_matrix(6'($urandom_range(JOINT_COUNT - 1)));
            end else if (roll < 14) begin
                joint = usable_joints[$urandom_range(usable_joints.size() - 1)];
                word  = $urandom_range(WORDS_PER_JOINT - 1);
                push_item(ACTION_LOAD, 6'(joint), 4'(word), matrix_word(word), 16'($urandom),
                          $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                          16'($urandom));
            end else if (roll < 18) begin
                push_item(ACTION_LOAD, 6'($urandom), 4'($urandom_range(12, 15)), $urandom,
                          16'($urandom), $urandom, $urandom, $urandom,
                          1'($urandom_range(1)), 16'($urandom));
            end else begin
                skin_vertex();
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
